@@ hdl/afb_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// afb_pkg
// Shared types, codes and widths for the admission FIFO with launch budget.
// ---------------------------------------------------------------------------
package afb_pkg;

  // default queue depth handed to the top level
  localparam int DEF_QUEUE_DEPTH = 16;

  // field widths
  localparam int OP_W       = 2;
  localparam int TAG_W      = 16;
  localparam int LVL_W      = 8;
  localparam int CAP_W      = 64;
  localparam int CNT_W      = 16;
  localparam int IN_TDATA_W = 96;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_QUEUE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LAUNCH = 2'd1;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BUDGET    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AUTH_MASK = 2'd2;

  // admission constants
  localparam logic [LVL_W-1:0] LEVEL_NEEDS_AUTH = 8'd2;
  localparam logic [CNT_W-1:0] COUNT_MAX        = 16'hFFFF;

  // one registered request
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             name_present;
    logic             secure_name;
    logic [TAG_W-1:0] service_tag;
    logic [LVL_W-1:0] req_level;
    logic [CAP_W-1:0] capability_word;
  } item_t;

  // engine to queue
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [TAG_W-1:0] tag;
    logic [LVL_W-1:0] level;
  } queue_cmd_t;

  // queue to engine
  typedef struct packed {
    logic full;
    logic empty;
    logic head_valid;
  } queue_stat_t;

endpackage
`default_nettype wire

@@ hdl/afb_in_reg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// afb_in_reg
// Input register: holds one request until the engine takes it.
// ---------------------------------------------------------------------------
module afb_in_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [afb_pkg::OP_W-1:0]         in_tuser,   // operation
  // name_present, secure_name, service_tag, requested level, capability_word
  input  logic [afb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             take,
  output logic                             item_valid,
  output afb_pkg::item_t                   item
);
  import afb_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // free when empty or when the held item leaves this cycle
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = in_tready ? in_tvalid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture on an input transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op              <= in_tuser;
      item_r.name_present    <= in_tdata[0];
      item_r.secure_name     <= in_tdata[1];
      item_r.service_tag     <= in_tdata[2 +: TAG_W];
      item_r.req_level       <= in_tdata[2 + TAG_W +: LVL_W];
      item_r.capability_word <= in_tdata[2 + TAG_W + LVL_W +: CAP_W];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

@@ hdl/afb_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// afb_queue
// Request storage: entry memory, pointers, occupancy and per-entry valid bits.
// ---------------------------------------------------------------------------
module afb_queue #(
  parameter  int QUEUE_DEPTH = afb_pkg::DEF_QUEUE_DEPTH,
  localparam int PTR_W       = $clog2(QUEUE_DEPTH),
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  afb_pkg::queue_cmd_t       cmd,
  output afb_pkg::queue_stat_t      stat,
  output logic [OCC_W-1:0]          count,
  output logic [afb_pkg::TAG_W-1:0] head_tag,
  output logic [afb_pkg::LVL_W-1:0] head_level
);
  import afb_pkg::*;

  localparam int ENT_W = TAG_W + LVL_W;

  logic [ENT_W-1:0]       mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]       rd_q_r;
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0]       count_r, count_nxt;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // entry write on push, registered head read on pop
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr_r] <= {cmd.level, cmd.tag};
    end
    if (cmd.pop) begin
      rd_q_r <= mem[rd_ptr_r];
    end
  end

  // pointer, occupancy and valid-bit updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    valid_nxt  = valid_r;
    if (cmd.push) begin
      wr_ptr_nxt          = ptr_inc(wr_ptr_r);
      count_nxt           = count_r + OCC_W'(1);
      valid_nxt[wr_ptr_r] = 1'b1;
    end
    if (cmd.pop) begin
      rd_ptr_nxt          = ptr_inc(rd_ptr_r);
      count_nxt           = count_r - OCC_W'(1);
      valid_nxt[rd_ptr_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      valid_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      valid_r  <= valid_nxt;
    end
  end

  assign stat.full       = (count_r == OCC_W'(QUEUE_DEPTH));
  assign stat.empty      = (count_r == '0);
  assign stat.head_valid = valid_r[rd_ptr_r];
  assign count           = count_r;
  assign head_tag        = rd_q_r[TAG_W-1:0];
  assign head_level      = rd_q_r[ENT_W-1:TAG_W];

`ifndef ASSERT_OFF
  // one request per cycle: never a push and a pop together
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.pop))
    else $error("queue push and pop in the same cycle");

  // occupancy bounded by depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // a non-empty queue always has a valid head entry
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> valid_r[rd_ptr_r])
    else $error("queue head not valid while occupied");

  // a push grows occupancy by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> (count_r == $past(count_r) + OCC_W'(1)))
    else $error("push did not grow occupancy");
`endif

endmodule
`default_nettype wire

@@ hdl/afb_engine.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// afb_engine
// Admission and launch decisions, configuration registers, counters and the
// result register with its handshake.
// ---------------------------------------------------------------------------
module afb_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [afb_pkg::CFG_DATA_W-1:0] cfg_data,
  // registered request
  input  logic                           item_valid,
  input  afb_pkg::item_t                 item,
  output logic                           take,
  // result handshake
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // queue
  input  afb_pkg::queue_stat_t           stat,
  output afb_pkg::queue_cmd_t            cmd,
  // result fields held in state
  output logic                           accepted,
  output logic                           launch_ok,
  output logic                           recent_from_pop,
  output logic [afb_pkg::LVL_W-1:0]      recent_level,
  output logic [afb_pkg::CNT_W-1:0]      launched_count,
  output logic [afb_pkg::CNT_W-1:0]      denied_count,
  output logic [afb_pkg::CNT_W-1:0]      ready_count
);
  import afb_pkg::*;

  logic             enabled_r;
  logic [CNT_W-1:0] budget_r;
  logic [CAP_W-1:0] auth_mask_r;

  logic             out_v_r, out_v_nxt;
  logic             accepted_r, launch_ok_r, src_pop_r;
  logic [LVL_W-1:0] recent_r;
  logic [CNT_W-1:0] launched_r, denied_r, ready_r;

  logic             is_queue, is_launch, auth_fail;
  logic             queue_go, launch_go, push, pop, deny;
  logic [CNT_W-1:0] budget_eff;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      budget_r    <= CNT_W'(1);
      auth_mask_r <= CAP_W'(1);
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_ENABLE:    enabled_r   <= cfg_data[0];
        REG_BUDGET:    budget_r    <= cfg_data[CNT_W-1:0];
        REG_AUTH_MASK: auth_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request moves into the result register when that slot frees up
  assign take = item_valid && (!out_v_r || out_tready);

  always_comb begin
    if (take) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // admission and launch decisions
  always_comb begin
    is_queue   = (item.op == OP_QUEUE);
    is_launch  = (item.op == OP_LAUNCH);
    auth_fail  = (item.req_level >= LEVEL_NEEDS_AUTH) && item.secure_name &&
                 ((item.capability_word & auth_mask_r) == '0);
    budget_eff = (budget_r == '0) ? CNT_W'(1) : budget_r;
    queue_go   = take && enabled_r && is_queue && item.name_present;
    launch_go  = take && enabled_r && is_launch && !stat.empty;
    push       = queue_go && !stat.full && !auth_fail;
    pop        = launch_go && (launched_r < budget_eff) && stat.head_valid;
    deny       = (queue_go && (stat.full || auth_fail)) ||
                 (launch_go && (launched_r >= budget_eff));
  end

  assign cmd.push  = push;
  assign cmd.pop   = pop;
  assign cmd.tag   = item.service_tag;
  assign cmd.level = item.req_level;

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      accepted_r  <= 1'b0;
      launch_ok_r <= 1'b0;
      src_pop_r   <= 1'b0;
      recent_r    <= '0;
      launched_r  <= '0;
      denied_r    <= '0;
      ready_r     <= '0;
    end else begin
      out_v_r <= out_v_nxt;
      if (take) begin
        accepted_r  <= push || pop;
        launch_ok_r <= pop;
      end
      if (push) begin
        recent_r  <= item.req_level;
        src_pop_r <= 1'b0;
      end
      if (pop) begin
        src_pop_r  <= 1'b1;
        launched_r <= sat_inc(launched_r);
        ready_r    <= sat_inc(ready_r);
      end
      if (deny) begin
        denied_r <= sat_inc(denied_r);
      end
    end
  end

  assign out_tvalid      = out_v_r;
  assign accepted        = accepted_r;
  assign launch_ok       = launch_ok_r;
  assign recent_from_pop = src_pop_r;
  assign recent_level    = recent_r;
  assign launched_count  = launched_r;
  assign denied_count    = denied_r;
  assign ready_count     = ready_r;

`ifndef ASSERT_OFF
  // a request is taken only when one is held
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> item_valid)
    else $error("request taken without a held item");

  // an accepted launch advances the launch count
  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && launched_r != COUNT_MAX) |=> (launched_r == $past(launched_r) + 1'b1))
    else $error("launch count did not advance on pop");

  // a request is never both launched and denied
  a_pop_deny: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && deny))
    else $error("launch and denial in the same cycle");
`endif

endmodule
`default_nettype wire

@@ hdl/admission_fifo_with_launch_budget.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// admission_fifo_with_launch_budget
// Bounded request queue with an admission rule and a launch budget.
// ---------------------------------------------------------------------------
// Takes one request per clock while the result side keeps up: a request
// transfer is registered in the input register, decided by the engine once
// the result register is free, and its result is loaded into the result
// register, from which it is offered. in_tready follows out_tready when both
// register stages are full. Launches read the entry memory through its single
// registered read port, loaded at the same edge as the result register, so
// the popped entry is ready together with the result.
// Configuration writes are always ready and must be issued while no request
// is in flight. Queue contents and counters survive disabling the block.
module admission_fifo_with_launch_budget #(
  parameter  int QUEUE_DEPTH = afb_pkg::DEF_QUEUE_DEPTH,
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1),
  localparam int RES_W       = afb_pkg::TAG_W + 2 * afb_pkg::LVL_W + OCC_W +
                               3 * afb_pkg::CNT_W,
  localparam int OUT_W       = ((RES_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [afb_pkg::OP_W-1:0]       in_tuser,   // operation
  // name_present, secure_name, service_tag, requested level, capability_word
  input  logic [afb_pkg::IN_TDATA_W-1:0] in_tdata,
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           out_tuser,  // accepted
  // popped_tag, popped_level, queued_count, launched_count, denied_count,
  // ready_count, recent_level
  output logic [OUT_W-1:0]               out_tdata,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [afb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import afb_pkg::*;

  logic        take, item_valid;
  item_t       item;
  queue_cmd_t  cmd;
  queue_stat_t stat;

  logic [OCC_W-1:0] count;
  logic [TAG_W-1:0] head_tag, popped_tag;
  logic [LVL_W-1:0] head_level, popped_level, recent_level, recent_held;
  logic             accepted, launch_ok, recent_from_pop;
  logic [CNT_W-1:0] launched_count, denied_count, ready_count;

  afb_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  afb_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item            (item),
    .take            (take),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .stat            (stat),
    .cmd             (cmd),
    .accepted        (accepted),
    .launch_ok       (launch_ok),
    .recent_from_pop (recent_from_pop),
    .recent_level    (recent_held),
    .launched_count  (launched_count),
    .denied_count    (denied_count),
    .ready_count     (ready_count)
  );

  afb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .count      (count),
    .head_tag   (head_tag),
    .head_level (head_level)
  );

  // popped fields read zero unless the latest request launched
  assign popped_tag   = launch_ok ? head_tag : '0;
  assign popped_level = launch_ok ? head_level : '0;
  // latest level: from the last pop read, or the last queued request
  assign recent_level = recent_from_pop ? head_level : recent_held;

  // result packing, first field lowest
  assign out_tuser = accepted;
  assign out_tdata = OUT_W'({recent_level, ready_count, denied_count, launched_count,
                             count, popped_level, popped_tag});

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the admission FIFO with launch budget.
// ---------------------------------------------------------------------------
// Requests go in on the input stream and each one answers with a single
// status result. A behavioral copy of the queue, the admission rule and the
// counters predicts every result at the moment its request transfers. Each
// result is then compared field by field against the oldest prediction.
// The run starts with a directed sweep of the admission and budget cases.
// Randomized phases follow: queue-heavy and launch-heavy bursts, so the FIFO
// fills and drains. Both stream sides stall in random bursts. The
// configuration is changed between phases, while nothing is in flight.
// ---------------------------------------------------------------------------
module tb_top;
  import afb_pkg::*;

  localparam int DEPTH      = DEF_QUEUE_DEPTH;
  localparam int OCC_W      = $clog2(DEPTH + 1);
  localparam int RES_W      = TAG_W + 2 * LVL_W + OCC_W + 3 * CNT_W;
  localparam int OUT_W      = ((RES_W + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_PRINTS = 40;

  // operation code the block treats as a status read
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // result field offsets in out_tdata
  localparam int P_TAG    = 0;
  localparam int P_LVL    = P_TAG + TAG_W;
  localparam int P_OCC    = P_LVL + LVL_W;
  localparam int P_LAUNCH = P_OCC + OCC_W;
  localparam int P_DENY   = P_LAUNCH + CNT_W;
  localparam int P_READY  = P_DENY + CNT_W;
  localparam int P_RECENT = P_READY + CNT_W;

  typedef struct packed {
    logic             accepted;
    logic [TAG_W-1:0] popped_tag;
    logic [LVL_W-1:0] popped_level;
    logic [OCC_W-1:0] queued;
    logic [CNT_W-1:0] launched;
    logic [CNT_W-1:0] denied;
    logic [CNT_W-1:0] made_ready;
    logic [LVL_W-1:0] recent_level;
  } status_t;

  // -------------------------------------------------------------------------
  // Behavioral copy of the queue and counters plus the list of pending
  // status results.
  // -------------------------------------------------------------------------
  class launch_queue_model;
    logic [TAG_W-1:0] slot_tag [DEPTH];
    logic [LVL_W-1:0] slot_level [DEPTH];
    bit               slot_valid [DEPTH];
    int               rd_idx;
    int               wr_idx;
    int               fill;
    logic [CNT_W-1:0] launches;
    logic [CNT_W-1:0] denials;
    logic [CNT_W-1:0] readied;
    logic [LVL_W-1:0] newest_level;
    bit               enabled;
    logic [CNT_W-1:0] budget_reg;
    logic [CAP_W-1:0] auth_mask;
    status_t          pending_status[$];
    int               errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_tag[i]   = '0;
        slot_level[i] = '0;
        slot_valid[i] = 1'b0;
      end
      rd_idx       = 0;
      wr_idx       = 0;
      fill         = 0;
      launches     = '0;
      denials      = '0;
      readied      = '0;
      newest_level = '0;
      enabled      = 1'b0;
      budget_reg   = 16'd1;
      auth_mask    = 64'd1;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_ENABLE:    enabled    = data[0];
        REG_BUDGET:    budget_reg = data[CNT_W-1:0];
        REG_AUTH_MASK: auth_mask  = data;
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // predict the status result of one request transfer
    function void note_request(logic [OP_W-1:0] op, logic name_ok, logic secure,
                               logic [TAG_W-1:0] tag, logic [LVL_W-1:0] lvl,
                               logic [CAP_W-1:0] caps);
      status_t          s;
      logic [CNT_W-1:0] limit;
      s = '0;
      if (op == OP_QUEUE) begin
        if (enabled && name_ok) begin
          if (fill >= DEPTH) begin
            denials = bump(denials);
          end else if (lvl >= LEVEL_NEEDS_AUTH && secure && (caps & auth_mask) == '0) begin
            denials = bump(denials);
          end else begin
            slot_tag[wr_idx]   = tag;
            slot_level[wr_idx] = lvl;
            slot_valid[wr_idx] = 1'b1;
            wr_idx             = (wr_idx + 1) % DEPTH;
            fill++;
            newest_level = lvl;
            s.accepted   = 1'b1;
          end
        end
      end else if (op == OP_LAUNCH) begin
        limit = (budget_reg == '0) ? 16'd1 : budget_reg;
        if (enabled && fill != 0) begin
          if (launches >= limit) begin
            denials = bump(denials);
          end else if (slot_valid[rd_idx]) begin
            slot_valid[rd_idx] = 1'b0;
            s.popped_tag       = slot_tag[rd_idx];
            s.popped_level     = slot_level[rd_idx];
            rd_idx             = (rd_idx + 1) % DEPTH;
            fill--;
            launches     = bump(launches);
            readied      = bump(readied);
            newest_level = s.popped_level;
            s.accepted   = 1'b1;
          end
        end
      end
      s.queued       = fill[OCC_W-1:0];
      s.launched     = launches;
      s.denied       = denials;
      s.made_ready   = readied;
      s.recent_level = newest_level;
      pending_status.push_back(s);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) report($sformatf("%s expected 0x%0h got 0x%0h", field, want, got));
    endtask

    // compare one result transfer with the oldest prediction
    task check_response(logic acc, logic [OUT_W-1:0] data);
      status_t s;
      if (pending_status.size() == 0) begin
        report("result transfer with no prediction pending");
      end else begin
        s = pending_status.pop_front();
        check_field("accepted", s.accepted, acc);
        check_field("popped_tag", s.popped_tag, data[P_TAG +: TAG_W]);
        check_field("popped_level", s.popped_level, data[P_LVL +: LVL_W]);
        check_field("queued_count", s.queued, data[P_OCC +: OCC_W]);
        check_field("launched_count", s.launched, data[P_LAUNCH +: CNT_W]);
        check_field("denied_count", s.denied, data[P_DENY +: CNT_W]);
        check_field("ready_count", s.made_ready, data[P_READY +: CNT_W]);
        check_field("recent_level", s.recent_level, data[P_RECENT +: LVL_W]);
      end
    endtask
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and block
  // -------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  wire                   in_tready;
  logic [OP_W-1:0]       in_tuser = OP_STATUS;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  wire                   out_tvalid;
  logic                  out_tready = 1'b1;
  wire                   out_tuser;
  wire  [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  admission_fifo_with_launch_budget #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  launch_queue_model fifo_model = new();

  bit              quiet = 1'b0;   // no stalls on either side
  int              in_gap_pct = 15;
  int              burst_left = 0;
  logic [OP_W-1:0] burst_op = OP_QUEUE;
  int              idle_cycles = 0;

  // -------------------------------------------------------------------------
  // Result side: random stall bursts, checking and the watchdog
  // -------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) fifo_model.check_response(out_tuser, out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  // one request transfer, with an optional idle burst ahead of it
  task send_request(logic [OP_W-1:0] op, logic name_ok, logic secure,
                    logic [TAG_W-1:0] tag, logic [LVL_W-1:0] lvl,
                    logic [CAP_W-1:0] caps);
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - CAP_W - LVL_W - TAG_W - 2){1'b0}},
                  caps, lvl, tag, secure, name_ok};
    do @(posedge clk); while (!in_tready);
    fifo_model.note_request(op, name_ok, secure, tag, lvl, caps);
  endtask

  // wait until every result is back, then let the pipeline settle
  task drain;
    in_tvalid <= 1'b0;
    while (fifo_model.pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fifo_model.write_reg(addr, data);
  endtask

  // random request shaped as queue or launch bursts, with some noise
  task random_request;
    logic [OP_W-1:0]  op;
    logic [LVL_W-1:0] lvl;
    logic [CAP_W-1:0] caps;
    int               pick;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      burst_op   = ($urandom_range(0, 1) == 0) ? OP_QUEUE : OP_LAUNCH;
    end
    burst_left--;
    pick = $urandom_range(0, 99);
    if (pick < 85)      op = burst_op;
    else if (pick < 90) op = OP_STATUS;
    else if (pick < 93) op = OP_UNUSED;
    else                op = (burst_op == OP_QUEUE) ? OP_LAUNCH : OP_QUEUE;
    case ($urandom_range(0, 4))
      0:       lvl = 8'd0;
      1:       lvl = 8'd1;
      2:       lvl = LEVEL_NEEDS_AUTH;
      3:       lvl = 8'hFF;
      default: lvl = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0:       caps = '0;
      1:       caps = {$urandom, $urandom};
      2:       caps = 64'd1 << $urandom_range(0, 63);
      default: caps = fifo_model.auth_mask;
    endcase
    send_request(op, $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                 16'($urandom_range(0, 16'hFFFF)), lvl, caps);
  endtask

  task random_phase(int count);
    for (int i = 0; i < count; i++) random_request();
    drain();
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled block after reset: everything refused, nothing counted
    send_request(OP_QUEUE, 1'b1, 1'b0, 16'h1234, 8'd0, '0);
    send_request(OP_LAUNCH, 1'b1, 1'b0, 16'h0, 8'd0, '0);
    send_request(OP_STATUS, 1'b1, 1'b1, 16'hFFFF, 8'hFF, '1);
    send_request(OP_UNUSED, 1'b1, 1'b1, 16'hFFFF, 8'hFF, '1);
    drain();

    // enabled, reset budget of one and reset mask
    cfg_write(REG_ENABLE, 64'd1);
    send_request(OP_QUEUE, 1'b0, 1'b0, 16'h5555, 8'd3, '0);     // no name
    send_request(OP_QUEUE, 1'b1, 1'b1, 16'h0000, 8'd0, '0);     // secure, low level
    send_request(OP_QUEUE, 1'b1, 1'b1, 16'hFFFF, 8'hFF, '0);    // secure, no auth
    send_request(OP_QUEUE, 1'b1, 1'b1, 16'hFFFF, LEVEL_NEEDS_AUTH, '1);
    send_request(OP_QUEUE, 1'b1, 1'b1, 16'hAAAA, 8'd1, '0);
    send_request(OP_QUEUE, 1'b1, 1'b0, 16'h5555, 8'hFF, '0);    // not secure
    send_request(OP_LAUNCH, 1'b0, 1'b0, 16'h0, 8'd0, '0);       // within budget
    send_request(OP_LAUNCH, 1'b1, 1'b0, 16'h0, 8'd0, '0);       // budget spent
    send_request(OP_STATUS, 1'b0, 1'b0, 16'h0, 8'd0, '0);
    drain();

    // zero budget acts as one
    cfg_write(REG_BUDGET, 64'd0);
    send_request(OP_LAUNCH, 1'b1, 1'b0, 16'h0, 8'd0, '0);
    drain();

    // largest budget, fill the FIFO and overflow it once
    cfg_write(REG_BUDGET, 64'hFFFF);
    cfg_write(REG_AUTH_MASK, '1);
    for (int i = 0; i < DEPTH - 3; i++)
      send_request(OP_QUEUE, 1'b1, 1'b0, 16'(i * 16'h1111), 8'(i), '0);
    send_request(OP_QUEUE, 1'b1, 1'b0, 16'h7777, 8'd7, '0);    // full
    drain();

    // random phases across several settings
    in_gap_pct = 20;
    random_phase(350);

    cfg_write(REG_AUTH_MASK, '0);
    in_gap_pct = 0;
    random_phase(250);

    cfg_write(REG_AUTH_MASK, 64'd1 << $urandom_range(0, 63));
    cfg_write(REG_BUDGET, (fifo_model.launches > 16'hFFF0) ?
                          64'hFFFF : 64'(fifo_model.launches + 16'd15));
    in_gap_pct = 30;
    random_phase(300);

    // disabled block keeps its queue and counters
    cfg_write(REG_ENABLE, 64'd0);
    in_gap_pct = 10;
    random_phase(100);

    cfg_write(REG_ENABLE, 64'd1);
    cfg_write(REG_BUDGET, 64'd0);
    cfg_write(REG_AUTH_MASK, {$urandom, $urandom});
    random_phase(100);

    // final stretch without stalls
    cfg_write(REG_BUDGET, 64'hFFFF);
    cfg_write(REG_AUTH_MASK, 64'h8000_0000_0000_0000);
    quiet = 1'b1;
    random_phase(670);

    repeat (10) @(posedge clk);
    if (fifo_model.errors == 0 && fifo_model.pending_status.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
